// File: rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, masked while reset is asserted.
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Clocked property that is checked through reset as well.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/fsc_pkg.sv
package fsc_pkg;

    localparam int NumPlanes = 6;
    localparam int CoordW    = 24;
    localparam int NormW     = 12;
    localparam int OffW      = 28;
    localparam int RadW      = 24;
    localparam int FracShift = 10;
    localparam int ProdW     = NormW + CoordW;   // exact normal * coordinate
    localparam int SumW      = ProdW + 5;        // three products + offset + radius
    localparam int DataW     = 64;
    localparam int AddrW     = 6;
    localparam int IdxW      = 3;

    // Plane register packing
    localparam int NxHi  = 63;
    localparam int NyHi  = 51;
    localparam int NzHi  = 39;
    localparam int OffHi = 27;

    // Register indexes (byte address = 8 * index)
    localparam logic [IdxW-1:0] RegPlaneLeft   = 3'd0;
    localparam logic [IdxW-1:0] RegPlaneRight  = 3'd1;
    localparam logic [IdxW-1:0] RegPlaneTop    = 3'd2;
    localparam logic [IdxW-1:0] RegPlaneBottom = 3'd3;
    localparam logic [IdxW-1:0] RegPlaneNear   = 3'd4;
    localparam logic [IdxW-1:0] RegPlaneFar    = 3'd5;
    localparam logic [IdxW-1:0] RegRadius      = 3'd6;

    localparam logic [RadW-1:0] RadiusReset = 24'd256;   // 1.0 in Q16.8

    typedef struct packed {
        logic signed [CoordW-1:0] pos_x;
        logic signed [CoordW-1:0] pos_y;
        logic signed [CoordW-1:0] pos_z;
    } t_pos_beat;

    typedef struct packed {
        logic signed [CoordW-1:0] vis_x;
        logic signed [CoordW-1:0] vis_y;
        logic signed [CoordW-1:0] vis_z;
    } t_vis_beat;

    // Load enables of the two lane stages
    typedef struct packed {
        logic s1;
        logic s2;
    } t_stage_en;

endpackage

// File: rtl/fsc_plane_lane.sv
module fsc_plane_lane import fsc_pkg::*; (
    input  logic             i_clk,
    input  t_stage_en        i_en,
    input  logic [DataW-1:0] i_plane,
    input  logic [RadW-1:0]  i_radius,
    input  t_pos_beat        i_pos,
    output logic             o_pass
);

    logic signed [NormW-1:0] nx, ny, nz;
    logic signed [OffW-1:0]  off;
    logic signed [ProdW-1:0] cx, cy, cz, nxe, nye, nze;
    logic signed [ProdW-1:0] n_prod_x, n_prod_y, n_prod_z;
    logic signed [ProdW-1:0] r_prod_x, r_prod_y, r_prod_z;
    logic signed [SumW-1:0]  ext_x, ext_y, ext_z, ext_off, ext_rad;
    logic signed [SumW-1:0]  n_part_a, n_part_b, r_part_a, r_part_b;
    logic signed [SumW-1:0]  total;

    assign nx  = i_plane[NxHi  -: NormW];
    assign ny  = i_plane[NyHi  -: NormW];
    assign nz  = i_plane[NzHi  -: NormW];
    assign off = i_plane[OffHi -: OffW];

    assign nxe = ProdW'(nx);
    assign nye = ProdW'(ny);
    assign nze = ProdW'(nz);
    assign cx  = ProdW'(i_pos.pos_x);
    assign cy  = ProdW'(i_pos.pos_y);
    assign cz  = ProdW'(i_pos.pos_z);

    // stage 1: the three products
    assign n_prod_x = nxe * cx;
    assign n_prod_y = nye * cy;
    assign n_prod_z = nze * cz;

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_prod_x <= n_prod_x;
            r_prod_y <= n_prod_y;
            r_prod_z <= n_prod_z;
        end
    end

    // stage 2: two partial sums; offset and radius moved to the Q.18 scale
    assign ext_x   = SumW'(r_prod_x);
    assign ext_y   = SumW'(r_prod_y);
    assign ext_z   = SumW'(r_prod_z);
    assign ext_off = SumW'(off) <<< FracShift;
    assign ext_rad = $signed({{(SumW-RadW){1'b0}}, i_radius}) <<< FracShift;

    assign n_part_a = ext_x + ext_y;
    assign n_part_b = ext_z + ext_off + ext_rad;

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_part_a <= n_part_a;
            r_part_b <= n_part_b;
        end
    end

    // n.c + d + r > 0, strict
    assign total  = r_part_a + r_part_b;
    assign o_pass = !total[SumW-1] && (total != '0);

endmodule

// File: rtl/frustum_sphere_cull_filter.sv
// A centre passes the product, partial-sum and output registers in that order.
// Throughput: one centre per cycle; stalls only when all three stages are full
//   and the output beat is held by the sink.
// Culled centres are dropped at the output register and leave a bubble behind.
// Reset (synchronous, active low) empties the pipeline, clears the six planes
//   to zero and sets the radius to 1.0.
module frustum_sphere_cull_filter import fsc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,

    // sphere centre stream in
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_pos_beat        i_in_data,

    // visible centre stream out
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_vis_beat        o_out_data,

    // register port
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    output logic [DataW-1:0] prdata,
    output logic             pready
);

    // ------------------------------------------------------------------
    // Register file: six planes plus radius, 8-byte stride
    // ------------------------------------------------------------------
    logic [DataW-1:0] r_plane [NumPlanes];
    logic [RadW-1:0]  r_radius;
    logic [IdxW-1:0]  reg_idx;
    logic             wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[AddrW-1 -: IdxW];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NumPlanes; p++) begin
                r_plane[p] <= '0;
            end
            r_radius <= RadiusReset;
        end else if (wr_en) begin
            case (reg_idx)
                RegPlaneLeft, RegPlaneRight, RegPlaneTop,
                RegPlaneBottom, RegPlaneNear, RegPlaneFar: begin
                    r_plane[reg_idx] <= pwdata;
                end
                RegRadius: begin
                    r_radius <= pwdata[RadW-1:0];
                end
                default: ;   // unmapped, write dropped
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            RegPlaneLeft, RegPlaneRight, RegPlaneTop,
            RegPlaneBottom, RegPlaneNear, RegPlaneFar: begin
                prdata = r_plane[reg_idx];
            end
            RegRadius: begin
                prdata = DataW'(r_radius);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline control. Each stage loads when it is empty or when the
    // stage after it moves, so bubbles (and culled slots) collapse.
    //   stage 1: products       stage 2: partial sums
    //   stage 3: output register, valid only for visible centres
    // ------------------------------------------------------------------
    logic      r_v1, r_v2, r_out_valid;
    t_pos_beat r_pos1, r_pos2;
    t_vis_beat r_out_data;
    logic      rdy1, rdy2, rdy3;
    t_stage_en stage_en;
    logic [NumPlanes-1:0] pass;
    logic      visible;

    assign rdy3 = !r_out_valid || i_out_ready;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;

    assign stage_en.s1 = rdy1;
    assign stage_en.s2 = rdy2;

    assign o_in_ready  = rdy1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_in_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_out_valid <= r_v2 && visible;
            end
        end
    end

    // centre travels beside the lane registers
    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_pos1 <= i_in_data;
        end
        if (rdy2) begin
            r_pos2 <= r_pos1;
        end
        if (rdy3) begin
            r_out_data <= t_vis_beat'(r_pos2);
        end
    end

    // ------------------------------------------------------------------
    // One lane per plane; a centre is visible only if all six pass
    // ------------------------------------------------------------------
    for (genvar g = 0; g < NumPlanes; g++) begin : g_lane
        fsc_plane_lane u_lane (
            .i_clk    (i_clk),
            .i_en     (stage_en),
            .i_plane  (r_plane[g]),
            .i_radius (r_radius),
            .i_pos    (i_in_data),
            .o_pass   (pass[g])
        );
    end

    assign visible = &pass;

endmodule

// File: rtl/fsc_checker.sv
`include "assert_macros.svh"

module fsc_checker import fsc_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input logic pready
);

    logic out_held;

    assign out_held = o_out_valid && !i_out_ready;

    // pipeline comes out of reset empty and open
    `ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid && o_in_ready, "reset state")

    // input backpressure only when the output beat is held
    `ASSERT_CLKD(a_stall_cause, i_clk, i_rst_n, !o_in_ready |-> out_held, "stall w/o hold")

    // a held output beat is not withdrawn
    `ASSERT_CLKD(a_out_hold, i_clk, i_rst_n, out_held |=> o_out_valid, "output beat dropped")

    // register port never waits
    `ASSERT_CLKD(a_pready, i_clk, i_rst_n, pready, "pready low")

endmodule

bind frustum_sphere_cull_filter fsc_checker u_fsc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .pready      (pready)
);

// File: tb/frustum_sphere_cull_filter_tb.sv
module frustum_sphere_cull_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fsc_pkg::*;

    localparam int ClkHalf       = 4;
    localparam int ResetCycles   = 11;
    localparam int SettleCycles  = 8;       // lets culled beats drain from the pipeline registers
    localparam int CycleLimit    = 400000;
    localparam int HoldOffCycles = 300;
    localparam int CfgPerPhase   = 7;
    localparam int BeatsPerCfg   = 66;

    // Index 7 is decoded by the address but holds no register.
    localparam logic [IdxW-1:0] RegUnused = 3'd7;

    // Q2.10 normals and Q20.8 offsets at their extremes
    localparam logic [NormW-1:0] NormOne    = 12'h400;   //  1.0
    localparam logic [NormW-1:0] NormNegOne = 12'hC00;   // -1.0
    localparam logic [NormW-1:0] NormMax    = 12'h7FF;
    localparam logic [NormW-1:0] NormMin    = 12'h800;
    localparam logic [OffW-1:0]  OffMax     = 28'h7FFFFFF;
    localparam logic [OffW-1:0]  OffMin     = 28'h8000000;
    localparam logic signed [CoordW-1:0] CoordMax = 24'sh7FFFFF;
    localparam logic signed [CoordW-1:0] CoordMin = 24'sh800000;

    logic             i_clk   = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    t_pos_beat        in_data = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    t_vis_beat        out_data;
    logic             psel    = 1'b0;
    logic             penable = 1'b0;
    logic             pwrite  = 1'b0;
    logic [AddrW-1:0] paddr   = '0;
    logic [DataW-1:0] pwdata  = '0;
    logic [DataW-1:0] prdata;
    logic             pready;

    // Shadow copy of the register file, updated on every register write
    logic [DataW-1:0] plane_cfg [NumPlanes];
    logic [RadW-1:0]  radius_cfg;

    t_vis_beat vis_expected_q [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_off_left = 0;
    int fail_cnt      = 0;
    int cycle_cnt     = 0;

    frustum_sphere_cull_filter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #(ClkHalf) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Visibility predictor: a center survives only if n.c + d > -r holds
    // for all six planes. Everything is brought to the Q.18 scale, so the
    // offset and the radius are shifted up by the normal's fraction bits.
    // ------------------------------------------------------------------
    function automatic bit sphere_is_visible(input t_pos_beat c);
        logic signed [CoordW-1:0] cx, cy, cz;
        logic signed [NormW-1:0]  nx, ny, nz;
        logic signed [OffW-1:0]   off;
        longint                   plane_sum, bound;
        bit                       vis;
        cx    = c.pos_x;
        cy    = c.pos_y;
        cz    = c.pos_z;
        bound = -(longint'(radius_cfg) * (longint'(1) << FracShift));
        vis   = 1'b1;
        for (int p = 0; p < NumPlanes; p++) begin
            nx   = plane_cfg[p][NxHi -: NormW];
            ny   = plane_cfg[p][NyHi -: NormW];
            nz   = plane_cfg[p][NzHi -: NormW];
            off  = plane_cfg[p][OffHi -: OffW];
            plane_sum = longint'(nx) * longint'(cx) + longint'(ny) * longint'(cy)
                      + longint'(nz) * longint'(cz)
                      + longint'(off) * (longint'(1) << FracShift);
            // strict: touching the plane exactly at -r culls
            if (!(plane_sum > bound)) vis = 1'b0;
        end
        return vis;
    endfunction

    function automatic logic [DataW-1:0] pack_plane(input logic [NormW-1:0] nx,
                                                    input logic [NormW-1:0] ny,
                                                    input logic [NormW-1:0] nz,
                                                    input logic [OffW-1:0]  off);
        return {nx, ny, nz, off};
    endfunction

    // Mix of full-range centers and centers clustered around the origin
    function automatic t_pos_beat random_pos();
        t_pos_beat   b;
        logic [95:0] r;
        if ($urandom_range(1)) begin
            r = {$urandom, $urandom, $urandom};
            b = r[3*CoordW-1:0];
        end else begin
            b.pos_x = CoordW'(int'($urandom_range(0, 8191)) - 4096);
            b.pos_y = CoordW'(int'($urandom_range(0, 8191)) - 4096);
            b.pos_z = CoordW'(int'($urandom_range(0, 8191)) - 4096);
        end
        return b;
    endfunction

    // ------------------------------------------------------------------
    // Register write: setup cycle, then access cycle until pready.
    // ------------------------------------------------------------------
    task automatic apb_write(input logic [IdxW-1:0] idx, input logic [DataW-1:0] val);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 3'b000};
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx < NumPlanes)
            plane_cfg[idx] = val;
        else if (idx == RegRadius)
            radius_cfg = val[RadW-1:0];
        // anything past the radius is dropped by the block
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Send one center beat. Valid stays high across back-to-back beats;
    // it only drops when the sender decides to idle.
    // ------------------------------------------------------------------
    task automatic send_pos(input t_pos_beat b);
        t_vis_beat v;
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            in_valid = 1'b0;
        end
        @(negedge i_clk);
        in_valid = 1'b1;
        in_data  = b;
        do @(posedge i_clk); while (!in_ready);
        if (sphere_is_visible(b)) begin
            v.vis_x = b.pos_x;
            v.vis_y = b.pos_y;
            v.vis_z = b.pos_z;
            vis_expected_q = {vis_expected_q, v};
        end
    endtask

    // Stop sending, let every visible center come out, then let any culled
    // beats still in flight fall out of the pipe.
    task automatic wait_idle();
        @(negedge i_clk);
        in_valid = 1'b0;
        while (vis_expected_q.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic zero_planes(input logic [RadW-1:0] rad);
        for (int p = RegPlaneLeft; p <= RegPlaneFar; p++)
            apb_write(IdxW'(p), '0);
        apb_write(RegRadius, DataW'(rad));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Out of reset all planes are zero and the radius is 1.0: nothing culls.
    task automatic test_reset_defaults();
        send_pos(t_pos_beat'{CoordMax, CoordMax, CoordMax});
        send_pos(t_pos_beat'{CoordMin, CoordMin, CoordMin});
        send_pos(t_pos_beat'{24'sd0, 24'sd0, 24'sd0});
        send_pos(t_pos_beat'{CoordMax, CoordMin, 24'sd0});
        send_pos(t_pos_beat'{CoordMin, 24'sd0, CoordMax});
    endtask

    // Zero planes with zero radius cull everything; a write to the unused
    // index must not disturb anything.
    task automatic test_zero_radius();
        wait_idle();
        apb_write(RegRadius, '0);
        send_pos(t_pos_beat'{24'sd0, 24'sd0, 24'sd0});
        send_pos(t_pos_beat'{CoordMax, CoordMax, CoordMax});
        wait_idle();
        apb_write(RegUnused, {$urandom, $urandom});
        send_pos(t_pos_beat'{CoordMin, CoordMin, CoordMin});
        send_pos(t_pos_beat'{CoordMax, CoordMin, CoordMax});
    endtask

    // Left plane x > -r, right plane -x + d > -r: centers on, inside and
    // outside the left boundary, on and inside the right one.
    task automatic test_strict_compare();
        wait_idle();
        apb_write(RegPlaneLeft,  pack_plane(NormOne, '0, '0, '0));
        apb_write(RegPlaneRight, pack_plane(NormNegOne, '0, '0, 28'd100));
        apb_write(RegRadius, DataW'(RadiusReset));
        send_pos(t_pos_beat'{-24'sd256, 24'sd0, 24'sd0});   // exactly -r: culled
        send_pos(t_pos_beat'{-24'sd255, 24'sd7, -24'sd7});
        send_pos(t_pos_beat'{-24'sd257, 24'sd0, 24'sd0});
        send_pos(t_pos_beat'{24'sd356, 24'sd0, 24'sd0});    // on the right boundary
        send_pos(t_pos_beat'{24'sd355, CoordMax, CoordMin});
    endtask

    // Largest normals and offsets against corner centers.
    task automatic test_extreme_planes();
        wait_idle();
        apb_write(RegPlaneLeft,   pack_plane(NormMax, NormMax, NormMax, OffMax));
        apb_write(RegPlaneRight,  pack_plane(NormMin, NormMin, NormMin, OffMax));
        apb_write(RegPlaneTop,    pack_plane(NormMax, NormMin, NormMax, OffMax));
        apb_write(RegPlaneBottom, pack_plane(NormMin, NormMax, NormMin, OffMax));
        apb_write(RegPlaneNear,   pack_plane(NormMax, NormMin, NormMin, OffMax));
        apb_write(RegPlaneFar,    pack_plane(NormMin, NormMax, NormMax, OffMax));
        apb_write(RegRadius, DataW'({RadW{1'b1}}));
        send_pos(t_pos_beat'{CoordMax, CoordMax, CoordMax});
        send_pos(t_pos_beat'{CoordMin, CoordMin, CoordMin});
        send_pos(t_pos_beat'{CoordMax, CoordMin, CoordMax});
        send_pos(t_pos_beat'{CoordMin, CoordMax, CoordMin});
        // far plane becomes x+y+z > 0 with no radius slack
        wait_idle();
        apb_write(RegPlaneFar, pack_plane(NormMax, NormMax, NormMax, '0));
        apb_write(RegPlaneNear, pack_plane('0, '0, '0, OffMin));
        apb_write(RegRadius, '0);
        send_pos(t_pos_beat'{CoordMax, CoordMax, CoordMax});
        wait_idle();
        apb_write(RegPlaneNear, pack_plane('0, '0, '0, OffMax));
        send_pos(t_pos_beat'{CoordMax, CoordMax, CoordMax});
        send_pos(t_pos_beat'{CoordMin, CoordMin, CoordMin});
        send_pos(t_pos_beat'{CoordMax, CoordMin, 24'sd0});
        send_pos(t_pos_beat'{24'sd0, 24'sd0, 24'sd0});
    endtask

    // Sink holds off for a long stretch while the source keeps pushing, so
    // the pipe fills and back-pressures its input.
    task automatic test_output_stall();
        int saved_pct;
        wait_idle();
        zero_planes(RadiusReset);
        saved_pct     = send_idle_pct;
        send_idle_pct = 0;
        hold_off_left = HoldOffCycles;
        for (int n = 0; n < 40; n++)
            send_pos(random_pos());
        send_idle_pct = saved_pct;
        wait_idle();
    endtask

    // Random frustums, each followed by a stream of random centers.
    task automatic test_random_phase(input int s_pct, input int r_pct);
        int               kind;
        logic [DataW-1:0] pl;
        logic [NormW-1:0] nrm [3];
        logic [OffW-1:0]  off;
        logic [RadW-1:0]  rad;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int cfg = 0; cfg < CfgPerPhase; cfg++) begin
            wait_idle();
            kind = $urandom_range(3);
            for (int p = RegPlaneLeft; p <= RegPlaneFar; p++) begin
                case (kind)
                    0: pl = {$urandom, $urandom};
                    1: pl = $urandom_range(1) ? '0 : {$urandom, $urandom};
                    2: begin
                        // axis-aligned box: left/right on x, top/bottom on y,
                        // near/far on z, inward-facing unit normals
                        nrm = '{default: '0};
                        nrm[p / 2] = (p % 2) ? NormNegOne : NormOne;
                        off = OffW'($urandom_range(0, 1 << 22));
                        pl  = pack_plane(nrm[0], nrm[1], nrm[2], off);
                    end
                    default: begin
                        for (int k = 0; k < 3; k++)
                            case ($urandom_range(2))
                                0:       nrm[k] = NormMax;
                                1:       nrm[k] = NormMin;
                                default: nrm[k] = '0;
                            endcase
                        case ($urandom_range(2))
                            0:       off = OffMax;
                            1:       off = OffMin;
                            default: off = OffW'($urandom);
                        endcase
                        pl = pack_plane(nrm[0], nrm[1], nrm[2], off);
                    end
                endcase
                apb_write(IdxW'(p), pl);
            end
            case (kind)
                0:     rad = RadW'($urandom);
                1, 2:  rad = RadW'($urandom_range(0, 65535));
                default:
                    case ($urandom_range(2))
                        0:       rad = '0;
                        1:       rad = '1;
                        default: rad = RadiusReset;
                    endcase
            endcase
            apb_write(RegRadius, DataW'(rad));
            for (int n = 0; n < BeatsPerCfg; n++) begin
                // one mid-stream pause until every visible center is back
                if (cfg == 0 && n == BeatsPerCfg / 2) wait_idle();
                send_pos(random_pos());
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sink: random ready, or a forced hold-off counted down here.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_off_left > 0) begin
            out_ready = 1'b0;
            hold_off_left--;
        end else begin
            out_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Output check: every accepted beat against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_vis
        t_vis_beat exp_b;
        if (i_rst_n && out_valid && out_ready) begin
            if (vis_expected_q.size() == 0) begin
                $error("unexpected visible beat: x %0d y %0d z %0d",
                       out_data.vis_x, out_data.vis_y, out_data.vis_z);
                fail_cnt++;
            end else begin
                exp_b = vis_expected_q.pop_front();
                if (out_data.vis_x !== exp_b.vis_x) begin
                    $error("vis_x: expected %0d, got %0d", exp_b.vis_x, out_data.vis_x);
                    fail_cnt++;
                end
                if (out_data.vis_y !== exp_b.vis_y) begin
                    $error("vis_y: expected %0d, got %0d", exp_b.vis_y, out_data.vis_y);
                    fail_cnt++;
                end
                if (out_data.vis_z !== exp_b.vis_z) begin
                    $error("vis_z: expected %0d, got %0d", exp_b.vis_z, out_data.vis_z);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog
    initial begin : watchdog
        while (cycle_cnt < CycleLimit) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        for (int p = 0; p < NumPlanes; p++)
            plane_cfg[p] = '0;
        radius_cfg    = RadiusReset;
        send_idle_pct = 12;
        recv_idle_pct = 54;

        repeat (ResetCycles) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_zero_radius();
        test_strict_compare();
        test_extreme_planes();
        test_output_stall();
        test_random_phase(12, 54);
        test_random_phase(54, 12);
        test_random_phase(0, 0);
        wait_idle();

        if (fail_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/fsc_pkg.sv
rtl/fsc_plane_lane.sv
rtl/frustum_sphere_cull_filter.sv
rtl/fsc_checker.sv
tb/frustum_sphere_cull_filter_tb.sv
